// ----- hw/rtl/gad_pkg.sv -----
`timescale 1ns / 1ps

package gad_pkg;

    localparam int IN_W          = 24;
    localparam int ANG_W         = 17;
    localparam int DEG_UNIT_BITS = 20;
    localparam int PRE_SHIFT     = 30;
    localparam int CORDIC_STEPS  = 27;
    localparam int MAG_W         = IN_W;
    localparam int XW            = 56;
    localparam int ZW            = 28;
    localparam int QW            = 27;
    localparam int FW            = 30;
    localparam int RND_SHIFT     = DEG_UNIT_BITS - 8;
    localparam int RW            = FW - RND_SHIFT;

    localparam logic signed [ZW-1:0] OCT_TOP  = ZW'(45 << DEG_UNIT_BITS);
    localparam logic [QW-1:0]        DEG90_Q  = QW'(90 << DEG_UNIT_BITS);
    localparam logic [FW-1:0]        DEG90_F  = FW'(90 << DEG_UNIT_BITS);
    localparam logic [FW-1:0]        DEG180_F = FW'(180 << DEG_UNIT_BITS);
    localparam logic [FW-1:0]        DEG270_F = FW'(270 << DEG_UNIT_BITS);
    localparam logic [FW-1:0]        DEG360_F = FW'(360 << DEG_UNIT_BITS);
    localparam logic [FW-1:0]        RND_HALF = FW'(1 << (RND_SHIFT - 1));
    localparam logic [RW-1:0]        FULL_CIRCLE_Q8 = RW'(92160);

    typedef struct packed {
        logic                   x_zero;
        logic                   x_neg;
        logic                   y_pos;
        logic                   y_neg;
        logic                   swap;
        logic signed [IN_W-1:0] dom;
    } gad_side_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        gad_side_t            side;
    } gad_cordic_t;

    function automatic logic signed [ZW-1:0] atan_deg(input int step);
        logic signed [ZW-1:0] a;
        case (step)
            0:       a = ZW'(47185920);
            1:       a = ZW'(27855475);
            2:       a = ZW'(14718068);
            3:       a = ZW'(7471121);
            4:       a = ZW'(3750058);
            5:       a = ZW'(1876857);
            6:       a = ZW'(938658);
            7:       a = ZW'(469357);
            8:       a = ZW'(234682);
            9:       a = ZW'(117342);
            10:      a = ZW'(58671);
            11:      a = ZW'(29335);
            12:      a = ZW'(14668);
            13:      a = ZW'(7334);
            14:      a = ZW'(3667);
            15:      a = ZW'(1833);
            16:      a = ZW'(917);
            17:      a = ZW'(458);
            18:      a = ZW'(229);
            19:      a = ZW'(115);
            20:      a = ZW'(57);
            21:      a = ZW'(29);
            22:      a = ZW'(14);
            23:      a = ZW'(7);
            24:      a = ZW'(4);
            25:      a = ZW'(2);
            26:      a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- hw/rtl/gad_cordic_step.sv -----
`timescale 1ns / 1ps

module gad_cordic_step
    import gad_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    input  gad_cordic_t up_data,
    output logic        up_ready,
    output logic        valid,
    output gad_cordic_t data,
    input  logic        down_ready
);

    localparam logic signed [ZW-1:0] ANGLE = atan_deg(STEP);

    logic                 valid_reg;
    gad_cordic_t          data_reg;
    gad_cordic_t          data_next;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    always_comb
    begin
        xi        = up_data.x;
        yi        = up_data.y;
        zi        = up_data.z;
        dx        = yi >>> STEP;
        dy        = xi >>> STEP;
        data_next = up_data;
        if (yi != '0)
        begin
            if (yi > 0)
            begin
                data_next.x = xi + dx;
                data_next.y = yi - dy;
                data_next.z = zi + ANGLE;
            end
            else
            begin
                data_next.x = xi - dx;
                data_next.y = yi + dy;
                data_next.z = zi - ANGLE;
            end
        end
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- hw/rtl/gradient_angle_and_dominant_unit.sv -----
`timescale 1ns / 1ps

// Channel   Signals                          Handshake
// -------   ------------------------------   ---------------------
// pixel     resp_horiz, resp_vert            pix_valid / pix_ready
// result    angle_deg, dominant_resp         res_valid / res_ready
//
// One request per cycle unless the result channel stalls; 32 register stages:
// input register, octant prep, 27 CORDIC rotation stages (one per shift),
// octant fold, quadrant unfold, round and wrap. Each stage holds a valid bit;
// a stage advances when it is empty or the next one advances, so bubbles
// collapse under stall.
// Reset clears the valid bits only.

module gradient_angle_and_dominant_unit
    import gad_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pix_valid,
    output logic                    pix_ready,
    input  logic signed [IN_W-1:0]  resp_horiz,
    input  logic signed [IN_W-1:0]  resp_vert,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [ANG_W-1:0]        angle_deg,
    output logic signed [IN_W-1:0]  dominant_resp
);

    // input register
    logic                   v0_reg;
    logic signed [IN_W-1:0] x_reg;
    logic signed [IN_W-1:0] y_reg;
    logic                   rdy0;

    // prep stage
    logic                   v1_reg;
    gad_cordic_t            c1_reg;
    gad_cordic_t            c1_next;
    logic                   rdy1;

    logic signed [IN_W:0]   xe;
    logic signed [IN_W:0]   ye;
    logic [MAG_W-1:0]       ax;
    logic [MAG_W-1:0]       ay;
    logic [MAG_W-1:0]       big;
    logic [MAG_W-1:0]       small_mag;
    logic signed [IN_W:0]   hi;
    logic signed [IN_W:0]   lo;
    logic [MAG_W-1:0]       abs_hi;
    logic [MAG_W-1:0]       abs_lo;

    // rotation chain
    gad_cordic_t            cd [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0]  cv;
    logic [CORDIC_STEPS:1]  cr;

    // octant fold
    logic                   v29_reg;
    logic [QW-1:0]          q_reg;
    logic [QW-1:0]          q_next;
    gad_side_t              s29_reg;
    logic [QW-1:0]          oct;
    logic signed [ZW-1:0]   zf;
    logic                   rdy29;

    // quadrant unfold
    logic                   v30_reg;
    logic [FW-1:0]          full_reg;
    logic [FW-1:0]          full_next;
    logic signed [IN_W-1:0] dom30_reg;
    logic [FW-1:0]          q_ext;
    logic                   rdy30;

    // round and wrap
    logic                   v31_reg;
    logic [ANG_W-1:0]       ang_reg;
    logic [ANG_W-1:0]       ang_next;
    logic signed [IN_W-1:0] dom31_reg;
    logic [FW-1:0]          rsum;
    logic [RW-1:0]          rq;
    logic                   rdy31;

    assign rdy31     = !v31_reg || res_ready;
    assign rdy30     = !v30_reg || rdy31;
    assign rdy29     = !v29_reg || rdy30;
    assign rdy1      = !v1_reg || cr[1];
    assign rdy0      = !v0_reg || rdy1;
    assign pix_ready = rdy0;

    // stage 0: hold raw request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (rdy0)
            v0_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && pix_valid)
        begin
            x_reg <= resp_horiz;
            y_reg <= resp_vert;
        end
    end

    // stage 1: magnitudes, octant reduction, dominant pick
    always_comb
    begin
        xe        = {x_reg[IN_W-1], x_reg};
        ye        = {y_reg[IN_W-1], y_reg};
        ax        = x_reg[IN_W-1] ? MAG_W'(-xe) : MAG_W'(xe);
        ay        = y_reg[IN_W-1] ? MAG_W'(-ye) : MAG_W'(ye);
        big       = (ay > ax) ? ay : ax;
        small_mag = (ay > ax) ? ax : ay;

        if (xe >= ye)
        begin
            hi = xe;
            lo = ye;
        end
        else
        begin
            hi = ye;
            lo = xe;
        end
        abs_hi = hi[IN_W] ? MAG_W'(-hi) : MAG_W'(hi);
        abs_lo = lo[IN_W] ? MAG_W'(-lo) : MAG_W'(lo);

        c1_next.x           = {{(XW-MAG_W-PRE_SHIFT){1'b0}}, big, {PRE_SHIFT{1'b0}}};
        c1_next.y           = {{(XW-MAG_W-PRE_SHIFT){1'b0}}, small_mag, {PRE_SHIFT{1'b0}}};
        c1_next.z           = '0;
        c1_next.side.x_zero = (x_reg == '0);
        c1_next.side.x_neg  = x_reg[IN_W-1];
        c1_next.side.y_pos  = !y_reg[IN_W-1] && (y_reg != '0);
        c1_next.side.y_neg  = y_reg[IN_W-1];
        c1_next.side.swap   = (ay > ax);
        c1_next.side.dom    = (abs_hi > abs_lo) ? IN_W'(hi) : IN_W'(lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && v0_reg)
            c1_reg <= c1_next;
    end

    // stages 2..28: one rotation per stage
    assign cd[0] = c1_reg;
    assign cv[0] = v1_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic dn_ready;
        if (k == CORDIC_STEPS - 1)
        begin : g_last
            assign dn_ready = rdy29;
        end
        else
        begin : g_mid
            assign dn_ready = cr[k+2];
        end

        gad_cordic_step #(
            .STEP (k)
        ) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (cv[k]),
            .up_data    (cd[k]),
            .up_ready   (cr[k+1]),
            .valid      (cv[k+1]),
            .data       (cd[k+1]),
            .down_ready (dn_ready)
        );
    end

    // stage 29: clamp octant angle, fold about 45 degrees
    always_comb
    begin
        zf = cd[CORDIC_STEPS].z;
        if (zf < 0)
            oct = '0;
        else if (zf > OCT_TOP)
            oct = QW'(OCT_TOP);
        else
            oct = QW'(zf);
        q_next = cd[CORDIC_STEPS].side.swap ? (DEG90_Q - oct) : oct;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v29_reg <= 1'b0;
        else if (rdy29)
            v29_reg <= cv[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (rdy29 && cv[CORDIC_STEPS])
        begin
            q_reg   <= q_next;
            s29_reg <= cd[CORDIC_STEPS].side;
        end
    end

    // stage 30: unfold to full circle
    always_comb
    begin
        q_ext = FW'(q_reg);
        if (s29_reg.x_zero)
            full_next = s29_reg.y_pos ? DEG90_F : DEG270_F;
        else if (!s29_reg.x_neg && !s29_reg.y_neg)
            full_next = q_ext;
        else if (s29_reg.x_neg && !s29_reg.y_neg)
            full_next = DEG180_F - q_ext;
        else if (s29_reg.x_neg)
            full_next = DEG180_F + q_ext;
        else
            full_next = DEG360_F - q_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v30_reg <= 1'b0;
        else if (rdy30)
            v30_reg <= v29_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy30 && v29_reg)
        begin
            full_reg  <= full_next;
            dom30_reg <= s29_reg.dom;
        end
    end

    // stage 31: round to Q9.8, wrap 360 to 0
    always_comb
    begin
        rsum     = full_reg + RND_HALF;
        rq       = rsum[FW-1:RND_SHIFT];
        ang_next = (rq >= FULL_CIRCLE_Q8) ? ANG_W'(rq - FULL_CIRCLE_Q8) : ANG_W'(rq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v31_reg <= 1'b0;
        else if (rdy31)
            v31_reg <= v30_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy31 && v30_reg)
        begin
            ang_reg   <= ang_next;
            dom31_reg <= dom30_reg;
        end
    end

    assign res_valid     = v31_reg;
    assign angle_deg     = ang_reg;
    assign dominant_resp = dom31_reg;

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (angle_deg < ANG_W'(FULL_CIRCLE_Q8)))
        else $error("angle out of range");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> v0_reg)
        else $error("accepted request not captured");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && (&cv) && v29_reg && v30_reg && v31_reg && !res_ready) |-> !pix_ready)
        else $error("request taken into a full stalled pipeline");

    a_drain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v30_reg && v31_reg && !res_ready) |=> (v30_reg && v31_reg))
        else $error("stalled stage dropped its request");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

import gad_pkg::*;

typedef struct {
    logic [ANG_W-1:0]        angle;
    logic signed [IN_W-1:0]  dom;
} pixel_result_t;

class gradient_ledger;
    pixel_result_t pending_results[$];
    int            mismatches;
    int            requests;
    int            results;
    longint        atan_q20 [CORDIC_STEPS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
        469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
        458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    function longint octant_q20(longint big, longint minor);
        longint xr;
        longint yr;
        longint zr;
        longint dx;
        longint dy;
        xr = big <<< PRE_SHIFT;
        yr = minor <<< PRE_SHIFT;
        zr = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (yr == 0)
                break;
            dx = yr >>> i;
            dy = xr >>> i;
            if (yr > 0)
            begin
                xr = xr + dx;
                yr = yr - dy;
                zr = zr + atan_q20[i];
            end
            else
            begin
                xr = xr - dx;
                yr = yr + dy;
                zr = zr - atan_q20[i];
            end
        end
        if (zr < 0)
            zr = 0;
        if (zr > (longint'(45) <<< DEG_UNIT_BITS))
            zr = longint'(45) <<< DEG_UNIT_BITS;
        return zr;
    endfunction

    function void note_request(logic signed [IN_W-1:0] h, logic signed [IN_W-1:0] v);
        longint        x;
        longint        y;
        longint        ax;
        longint        ay;
        longint        unit_deg;
        longint        q;
        longint        full;
        longint        ang;
        longint        hi;
        longint        lo;
        longint        ahi;
        longint        alo;
        pixel_result_t r;
        x = h;
        y = v;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        unit_deg = longint'(1) <<< DEG_UNIT_BITS;
        if (x == 0)
            full = ((y > 0) ? 90 : 270) * unit_deg;
        else
        begin
            if (ay > ax)
                q = 90 * unit_deg - octant_q20(ay, ax);
            else
                q = octant_q20(ax, ay);
            if (x > 0 && y >= 0)
                full = q;
            else if (x < 0 && y >= 0)
                full = 180 * unit_deg - q;
            else if (x < 0)
                full = 180 * unit_deg + q;
            else
                full = 360 * unit_deg - q;
        end
        ang = (full + (longint'(1) <<< (DEG_UNIT_BITS - 9))) >>> (DEG_UNIT_BITS - 8);
        if (ang >= 92160)
            ang = ang - 92160;
        if (x >= y)
        begin
            hi = x;
            lo = y;
        end
        else
        begin
            hi = y;
            lo = x;
        end
        ahi = (hi < 0) ? -hi : hi;
        alo = (lo < 0) ? -lo : lo;
        r.angle = ANG_W'(ang);
        r.dom   = IN_W'((ahi > alo) ? hi : lo);
        pending_results.push_back(r);
        requests++;
    endfunction

    task report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results);
        mismatches++;
    endtask

    task check_result(logic [ANG_W-1:0] angle, logic signed [IN_W-1:0] dom);
        pixel_result_t e;
        if (pending_results.size() == 0)
        begin
            report("result with no pending request, angle", angle, 0);
            return;
        end
        e = pending_results.pop_front();
        if (angle !== e.angle)
            report("angle_deg", angle, e.angle);
        if (dom !== e.dom)
            report("dominant_resp", dom, e.dom);
        results++;
    endtask
endclass

module tb;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_ready;
    logic signed [IN_W-1:0] resp_horiz = '0;
    logic signed [IN_W-1:0] resp_vert = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [ANG_W-1:0]       angle_deg;
    logic signed [IN_W-1:0] dominant_resp;

    gradient_ledger book = new();
    bit             steady = 1'b0;
    int             hold_left = 0;
    int             quiet_cycles = 0;

    localparam logic signed [IN_W-1:0] VMAX = 24'sh7fffff;
    localparam logic signed [IN_W-1:0] VMIN = 24'sh800000;

    gradient_angle_and_dominant_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_ready    (pix_ready),
        .resp_horiz   (resp_horiz),
        .resp_vert    (resp_vert),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .angle_deg    (angle_deg),
        .dominant_resp(dominant_resp)
    );

    always #5 clk = ~clk;

    task send_pixel(logic signed [IN_W-1:0] h, logic signed [IN_W-1:0] v);
        int gaps;
        pix_valid  <= 1'b1;
        resp_horiz <= h;
        resp_vert  <= v;
        do
            @(negedge clk);
        while (!pix_ready);
        @(posedge clk);
        book.note_request(h, v);
        gaps = 0;
        if (!steady)
            while ($urandom_range(0, 99) < 13)
                gaps++;
        if (gaps > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
    endtask

    task drain_results();
        pix_valid <= 1'b0;
        while (book.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task pick_pixel(output logic signed [IN_W-1:0] h, output logic signed [IN_W-1:0] v);
        int                     sel;
        logic signed [IN_W-1:0] m;
        logic signed [IN_W-1:0] t;
        sel = $urandom_range(0, 99);
        h = IN_W'($urandom);
        v = IN_W'($urandom);
        if (sel < 45)
            return;
        if (sel < 65)
        begin
            h = IN_W'(int'($urandom_range(0, 32)) - 16);
            v = IN_W'(int'($urandom_range(0, 32)) - 16);
        end
        else if (sel < 75)
        begin
            if ($urandom_range(0, 1))
                h = '0;
            else
                v = '0;
        end
        else if (sel < 85)
        begin
            m = IN_W'($urandom >> $urandom_range(0, 22));
            h = $urandom_range(0, 1) ? m : -m;
            v = $urandom_range(0, 1) ? m : -m;
        end
        else
        begin
            v = IN_W'(int'($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 1))
            begin
                t = h;
                h = v;
                v = t;
            end
        end
    endtask

    initial
    begin
        logic [ANG_W-1:0]       a;
        logic signed [IN_W-1:0] d;
        bit                     took;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            took = res_valid && res_ready;
            a = angle_deg;
            d = dominant_resp;
            @(posedge clk);
            if (took)
                book.check_result(a, d);
            if (hold_left > 0)
            begin
                res_ready <= 1'b0;
                hold_left--;
            end
            else
                res_ready <= steady || ($urandom_range(0, 99) >= 13);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if ((pix_valid && pix_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 3000)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [IN_W-1:0] h;
        logic signed [IN_W-1:0] v;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(0, 0);
        send_pixel(0, 1);
        send_pixel(0, -1);
        send_pixel(0, VMAX);
        send_pixel(0, VMIN);
        send_pixel(1, 0);
        send_pixel(-1, 0);
        send_pixel(VMAX, 0);
        send_pixel(VMIN, 0);
        send_pixel(VMAX, VMAX);
        send_pixel(VMIN, VMIN);
        send_pixel(VMAX, VMIN);
        send_pixel(VMIN, VMAX);
        send_pixel(5, 5);
        send_pixel(-5, 5);
        send_pixel(5, -5);
        send_pixel(-5, -5);
        send_pixel(VMAX, -1);
        send_pixel(VMIN, 1);
        send_pixel(VMIN, -1);
        send_pixel(3, 4);
        send_pixel(-24'sh123456, 24'sh07ff00);
        send_pixel(-1, VMIN);

        for (int n = 0; n < 1250; n++)
        begin
            if (n == 250)
                steady = 1'b1;
            if (n == 500)
                steady = 1'b0;
            if (n == 650)
                hold_left = 300;
            if (n == 900)
                drain_results();
            pick_pixel(h, v);
            send_pixel(h, v);
        end
        drain_results();
        repeat (40) @(posedge clk);
        if (book.pending_results.size() != 0)
            book.report("requests left without result", book.pending_results.size(), 0);

        $display("Checked %0d pixel requests against %0d results: axis, tie and extreme",
                 book.requests, book.results);
        $display("values, random gaps on both sides, a long output hold-off and a full drain");
        if (book.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
